### hw/rtl/ssrl_pkg.sv
// Shared types and constants of the steering servo rate limiter.
// No dependencies; ssrl_cfg_if, ssrl_regs, ssrl_div and the top level refer to it by scoped names.

package ssrl_pkg;

	// Register map of the configuration port
	typedef enum logic [2:0] {
		REG_SAFE_LIMIT   = 3'd0,
		REG_MAX_STEP     = 3'd1,
		REG_MIN_INTERVAL = 3'd2,
		REG_FULL_SCALE   = 3'd3,
		REG_CENTER_PWM   = 3'd4,
		REG_LEFT_PWM     = 3'd5,
		REG_RIGHT_PWM    = 3'd6
	} reg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// Reset values of the registers
	localparam logic [6:0]  RST_SAFE_LIMIT   = 7'd20;
	localparam logic [6:0]  RST_MAX_STEP     = 7'd5;
	localparam logic [9:0]  RST_MIN_INTERVAL = 10'd80;
	localparam logic [6:0]  RST_FULL_SCALE   = 7'd30;
	localparam logic [11:0] RST_CENTER_PWM   = 12'd307;
	localparam logic [11:0] RST_LEFT_PWM     = 12'd205;
	localparam logic [11:0] RST_RIGHT_PWM    = 12'd410;

	// Input mode codes
	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_CMD  = 1'b1;

	// Divider sizing: |angle| * |pwm span| fits 19 bits, quotient fits 12 bits
	localparam int DVD_W  = 19;
	localparam int DSR_W  = 7;
	localparam int QUOT_W = 12;

	typedef struct packed {
		logic [6:0]  safe_limit;
		logic [6:0]  max_step;
		logic [9:0]  min_interval;
		logic [6:0]  full_scale;
		logic [11:0] center_pwm;
		logic [11:0] left_pwm;
		logic [11:0] right_pwm;
	} cfg_t;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SLEW,
		S_CLAMP,
		S_MUL,
		S_START,
		S_DIV,
		S_SUM
	} state_t;

endpackage

### hw/rtl/ssrl_cmd_if.sv
// Input channel of the steering servo rate limiter: ticks and steering commands.
// Depends on nothing.

interface ssrl_cmd_if;
	logic              valid;
	logic              ready;
	logic              mode;
	logic signed [7:0] target_angle;

	modport source (output valid, mode, target_angle, input ready);
	modport sink   (input valid, mode, target_angle, output ready);
endinterface

### hw/rtl/ssrl_res_if.sv
// Result channel of the steering servo rate limiter: PWM count and applied angle.
// Depends on nothing.

interface ssrl_res_if;
	logic              valid;
	logic              ready;
	logic [11:0]       pwm_count;
	logic signed [7:0] applied_angle;

	modport source (output valid, pwm_count, applied_angle, input ready);
	modport sink   (input valid, pwm_count, applied_angle, output ready);
endinterface

### hw/rtl/ssrl_cfg_if.sv
// Configuration write channel of the steering servo rate limiter.
// Depends on ssrl_pkg for the index and data widths.

interface ssrl_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ssrl_pkg::CFG_IDX_W-1:0]  index;
	logic [ssrl_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/ssrl_regs.sv
// Configuration register file of the steering servo rate limiter.
// Depends on ssrl_pkg and ssrl_cfg_if.

module ssrl_regs (
	input  logic              clk,
	input  logic              arst_n,
	ssrl_cfg_if.sink          cfg,
	output ssrl_pkg::cfg_t    regs
);

	ssrl_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.safe_limit   <= ssrl_pkg::RST_SAFE_LIMIT;
			regs_q.max_step     <= ssrl_pkg::RST_MAX_STEP;
			regs_q.min_interval <= ssrl_pkg::RST_MIN_INTERVAL;
			regs_q.full_scale   <= ssrl_pkg::RST_FULL_SCALE;
			regs_q.center_pwm   <= ssrl_pkg::RST_CENTER_PWM;
			regs_q.left_pwm     <= ssrl_pkg::RST_LEFT_PWM;
			regs_q.right_pwm    <= ssrl_pkg::RST_RIGHT_PWM;
		end else if (cfg.valid) begin
			// unused index: drop the word
			unique case (ssrl_pkg::reg_idx_t'(cfg.index))
				ssrl_pkg::REG_SAFE_LIMIT:   regs_q.safe_limit   <= cfg.data[6:0];
				ssrl_pkg::REG_MAX_STEP:     regs_q.max_step     <= cfg.data[6:0];
				ssrl_pkg::REG_MIN_INTERVAL: regs_q.min_interval <= cfg.data[9:0];
				ssrl_pkg::REG_FULL_SCALE:   regs_q.full_scale   <= cfg.data[6:0];
				ssrl_pkg::REG_CENTER_PWM:   regs_q.center_pwm   <= cfg.data;
				ssrl_pkg::REG_LEFT_PWM:     regs_q.left_pwm     <= cfg.data;
				ssrl_pkg::REG_RIGHT_PWM:    regs_q.right_pwm    <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

### hw/rtl/ssrl_div.sv
// Shift-and-subtract divider of the steering servo rate limiter, one quotient bit a cycle.
// Depends on ssrl_pkg. Needs dividend < divisor * 2**QUOT_W.

module ssrl_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ssrl_pkg::div_ctl_t             ctl,
	input  logic [ssrl_pkg::DVD_W-1:0]     dividend,
	input  logic [ssrl_pkg::DSR_W-1:0]     divisor,
	output ssrl_pkg::div_sts_t             sts,
	output logic [ssrl_pkg::QUOT_W-1:0]    quotient
);

	localparam int SH_W  = ssrl_pkg::DSR_W + ssrl_pkg::QUOT_W - 1;
	localparam int CNT_W = $clog2(ssrl_pkg::QUOT_W);

	logic                          busy_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [ssrl_pkg::DVD_W-1:0]    rem_q;
	logic [SH_W-1:0]               dsr_q;
	logic [ssrl_pkg::QUOT_W-1:0]   quot_q;
	logic [ssrl_pkg::DVD_W-1:0]    dsr_ext;
	logic                          fits;

	assign dsr_ext = ssrl_pkg::DVD_W'(dsr_q);
	assign fits    = rem_q >= dsr_ext;

	assign sts.busy = busy_q;
	assign sts.done = busy_q && (cnt_q == '0);
	assign quotient = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(ssrl_pkg::QUOT_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q  <= dividend;
			dsr_q  <= {divisor, {(ssrl_pkg::QUOT_W-1){1'b0}}};
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsr_ext;
			end
			quot_q <= {quot_q[ssrl_pkg::QUOT_W-2:0], fits};
			dsr_q  <= dsr_q >> 1;
		end
	end

endmodule

### hw/rtl/steering_servo_rate_limiter.sv
// Top level of the steering servo rate limiter: tick counter, slew limit, PWM mapping.
// Depends on ssrl_pkg, the three channel interfaces, ssrl_regs and ssrl_div.
//
//  port  direction  word                         accepted when
//  cmd   in         mode, target_angle           cmd.valid && cmd.ready
//  res   out        pwm_count, applied_angle     res.valid && res.ready
//  cfg   in         index, data                  cfg.valid && cfg.ready (always ready)
//
// A tick word is taken and counted, and a command word that comes too early is taken and
// dropped; cmd stays ready for both. An accepted command steps through slew, clamp,
// multiply and divider start, then through the shift-and-subtract divider, then through
// the final add and saturate into the result register. A zero product skips the divider.
// cmd is not ready while a command is in flight.
// The result sits in an output register; the next word is accepted while it waits. A new
// result waits in the final step until the old one is taken.
// Reset (arst_n low) loads the register defaults, clears the tick count and the previous
// angle and empties the output register.

module steering_servo_rate_limiter #(
	parameter int PWM_BITS  = 12,
	parameter int TICK_BITS = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	ssrl_cmd_if.sink   cmd,
	ssrl_res_if.source res,
	ssrl_cfg_if.sink   cfg
);

	localparam int CMP_W = (TICK_BITS > 10) ? TICK_BITS : 10;
	localparam logic signed [17:0] PWM_MAX = 18'((1 << PWM_BITS) - 1);

	ssrl_pkg::cfg_t     regs;
	ssrl_pkg::state_t   state_q, state_d;
	ssrl_pkg::div_ctl_t div_ctl;
	ssrl_pkg::div_sts_t div_sts;

	logic [TICK_BITS-1:0]           ticks_q;
	logic signed [7:0]              prev_q;
	logic signed [7:0]              tgt_q;
	logic signed [8:0]              slew_q;
	logic signed [7:0]              fin_q;
	logic [6:0]                     mag_q;
	logic [11:0]                    dmag_q;
	logic                           neg_q;
	logic                           zero_q;
	logic [ssrl_pkg::DVD_W-1:0]     prod_q;
	logic [ssrl_pkg::QUOT_W-1:0]    quot;

	logic                           res_valid_q;
	logic [11:0]                    pwm_q;
	logic signed [7:0]              ang_out_q;

	logic cmd_take;
	logic is_cmd;
	logic passed;
	logic out_free;

	logic signed [8:0]  safe_ang;
	logic signed [9:0]  diff;
	logic signed [9:0]  step10;
	logic signed [8:0]  step9;
	logic signed [8:0]  prev9;
	logic signed [8:0]  slew_ang;
	logic signed [8:0]  clamp_ang;
	logic signed [12:0] span;
	logic signed [17:0] pwm_raw;
	logic [15:0]        pwm_sat;

	function automatic logic signed [8:0] clamp_sym(input logic signed [8:0] v,
	                                                input logic [6:0] lim);
		logic signed [8:0] hi;
		logic signed [8:0] lo;
		hi = $signed({2'b00, lim});
		lo = -hi;
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	ssrl_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	ssrl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (prod_q),
		.divisor  (regs.full_scale),
		.sts      (div_sts),
		.quotient (quot)
	);

	// Handshake side
	assign cmd_take = cmd.valid && cmd.ready;
	assign is_cmd   = (cmd.mode == ssrl_pkg::MODE_CMD);
	assign passed   = CMP_W'(ticks_q) >= CMP_W'(regs.min_interval);
	assign out_free = !res_valid_q || res.ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ssrl_pkg::S_IDLE:  if (cmd.valid && is_cmd && passed) state_d = ssrl_pkg::S_SLEW;
			ssrl_pkg::S_SLEW:  state_d = ssrl_pkg::S_CLAMP;
			ssrl_pkg::S_CLAMP: state_d = ssrl_pkg::S_MUL;
			ssrl_pkg::S_MUL:   state_d = ssrl_pkg::S_START;
			ssrl_pkg::S_START: state_d = zero_q ? ssrl_pkg::S_SUM : ssrl_pkg::S_DIV;
			ssrl_pkg::S_DIV:   if (div_sts.done) state_d = ssrl_pkg::S_SUM;
			ssrl_pkg::S_SUM:   if (out_free) state_d = ssrl_pkg::S_IDLE;
			default:           state_d = ssrl_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		cmd.ready     = (state_q == ssrl_pkg::S_IDLE);
		div_ctl.start = (state_q == ssrl_pkg::S_START) && !zero_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssrl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Tick counter and previous angle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= '0;
			prev_q  <= '0;
		end else begin
			if (cmd_take && !is_cmd) begin
				// saturate at all ones
				if (ticks_q != '1) ticks_q <= ticks_q + 1'b1;
			end else if (cmd_take && is_cmd && passed) begin
				ticks_q <= '0;
			end
			if (state_q == ssrl_pkg::S_SUM && out_free) begin
				prev_q <= fin_q;
			end
		end
	end

	// First clamp then slew limit around the previous angle
	always_comb begin
		safe_ang = clamp_sym(9'(tgt_q), regs.safe_limit);
		prev9    = 9'(prev_q);
		step9    = $signed({2'b00, regs.max_step});
		step10   = $signed({3'b000, regs.max_step});
		diff     = 10'(safe_ang) - 10'(prev9);
		if (diff > step10) begin
			slew_ang = prev9 + step9;
		end else if (diff < -step10) begin
			slew_ang = prev9 - step9;
		end else begin
			slew_ang = safe_ang;
		end
	end

	// Final clamp and choice of the PWM span for the side of the angle
	always_comb begin
		clamp_ang = clamp_sym(slew_q, regs.full_scale);
		if (clamp_ang[8]) begin
			span = $signed({1'b0, regs.center_pwm}) - $signed({1'b0, regs.left_pwm});
		end else begin
			span = $signed({1'b0, regs.right_pwm}) - $signed({1'b0, regs.center_pwm});
		end
	end

	// Add the signed quotient to the center count and saturate
	always_comb begin
		if (zero_q) begin
			pwm_raw = 18'($signed({1'b0, regs.center_pwm}));
		end else if (neg_q) begin
			pwm_raw = 18'($signed({1'b0, regs.center_pwm})) - 18'($signed({1'b0, quot}));
		end else begin
			pwm_raw = 18'($signed({1'b0, regs.center_pwm})) + 18'($signed({1'b0, quot}));
		end
		if (pwm_raw < 0) begin
			pwm_sat = '0;
		end else if (pwm_raw > PWM_MAX) begin
			pwm_sat = PWM_MAX[15:0];
		end else begin
			pwm_sat = pwm_raw[15:0];
		end
	end

	// Datapath registers, advanced one step per sequencer state
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			tgt_q <= cmd.target_angle;
		end
		if (state_q == ssrl_pkg::S_SLEW) begin
			slew_q <= slew_ang;
		end
		if (state_q == ssrl_pkg::S_CLAMP) begin
			fin_q  <= clamp_ang[7:0];
			mag_q  <= clamp_ang[8] ? 7'(-clamp_ang) : clamp_ang[6:0];
			dmag_q <= span[12] ? 12'(-span) : span[11:0];
			neg_q  <= clamp_ang[8] ^ span[12];
			zero_q <= (clamp_ang == '0) || (span == '0);
		end
		if (state_q == ssrl_pkg::S_MUL) begin
			prod_q <= ssrl_pkg::DVD_W'(mag_q * dmag_q);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ssrl_pkg::S_SUM && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ssrl_pkg::S_SUM && out_free) begin
			pwm_q     <= pwm_sat[11:0];
			ang_out_q <= fin_q;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.pwm_count     = pwm_q;
	assign res.applied_angle = ang_out_q;

endmodule
